@@ rtl/assert_macros.svh @@
// Assertion macros used by the timer queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

@@ rtl/sstq_pkg.sv @@
// Package with types and constants of the sorted timer queue.
package sstq_pkg;
    localparam int NUM_CHANNELS = 8;
    localparam int CH_W = 3;
    localparam int TIME_W = 63;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [2:0] CMD_TICK = 3'd0;
    localparam logic [2:0] CMD_ONCE = 3'd1;
    localparam logic [2:0] CMD_PERIODIC = 3'd2;
    localparam logic [2:0] CMD_RESTART = 3'd3;
    localparam logic [2:0] CMD_STOP = 3'd4;
    localparam logic [2:0] CMD_QUERY = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID_ARG = 2'd1;
    localparam logic [1:0] ST_INVALID_STATE = 2'd2;
    localparam logic [1:0] ST_NOT_SUPPORTED = 2'd3;

    typedef struct packed {
        logic valid;
        logic [CH_W-1:0] ch;
        logic [TIME_W-1:0] expiry;
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE, S_DROP, S_INSERT, S_SCAN, S_FIRE, S_OUT
    } state_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction
endpackage

@@ rtl/sstq_cell.sv @@
// One slot of the sorted list; shifts toward the head on drop, inserts in place.
module sstq_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              drop_en,
    input  logic [sstq_pkg::CH_W-1:0] drop_ch,
    input  logic              drop_prev,
    output logic              drop_out,
    input  logic              ins_en,
    input  sstq_pkg::slot_t   ins_slot,
    input  logic              ins_prev,
    output logic              ins_out,
    input  sstq_pkg::slot_t   left_slot,
    input  sstq_pkg::slot_t   right_slot,
    output sstq_pkg::slot_t   slot
);
    sstq_pkg::slot_t slot_reg, slot_next;
    logic match, later;

    assign slot = slot_reg;
    assign match = slot_reg.valid && slot_reg.ch == drop_ch;
    assign drop_out = drop_prev || match;
    assign later = !slot_reg.valid || slot_reg.expiry > ins_slot.expiry;
    assign ins_out = ins_prev || later;

    always_comb begin
        slot_next = slot_reg;
        if (drop_en && drop_out) begin
            slot_next = right_slot;
        end else if (ins_en && ins_out) begin
            slot_next = ins_prev ? left_slot : ins_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else begin
            slot_reg.valid <= slot_next.valid;
        end
        slot_reg.ch <= slot_next.ch;
        slot_reg.expiry <= slot_next.expiry;
    end
endmodule

@@ rtl/sorted_software_timer_queue_unit.sv @@
// Top level of the sorted timer queue: command sequencer around a chain of list cells.
// A command result is registered after the drop and insert states; the next request is taken in idle.
// A tick with nothing due answers after scan; a tick that fires k channels answers once per channel, via
// the fire, drop, insert and output states: one drop, plus one insert if periodic, in the cell chain.
// A result still waiting on the output holds the sequencer in its output state until it is taken.
// Reset (synchronous, active low) clears time, channel state and the list.
`include "assert_macros.svh"
module sorted_software_timer_queue_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [2:0] command, [5:3] timer_index, [68:6] duration_us, zero fill
    input  logic [71:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] channel, [4:3] status_code, [5] channel_active, [68:6] channel_period,
    // [131:69] channel_expiry, [194:132] next_alarm, [257:195] now_us, zero fill
    output logic [263:0] m_tdata,
    // [0] result_kind
    output logic         m_tuser,
    output logic         m_tlast
);
    localparam int N = sstq_pkg::NUM_CHANNELS;
    localparam int CW = sstq_pkg::CH_W;
    localparam int TW = sstq_pkg::TIME_W;

    sstq_pkg::state_t state_reg, state_next;
    logic [2:0] cmd_reg;
    logic [CW-1:0] idx_reg;
    logic [TW-1:0] dur_reg, now_reg;
    logic [N-1:0] armed_reg;
    logic [TW-1:0] period_reg [N];
    logic [TW-1:0] expiry_reg [N];
    logic fired_reg, kind_reg, arm_reg;
    logic [CW-1:0] fch_reg;
    logic [1:0] st_reg;
    logic [263:0] tdata_reg;
    logic tuser_reg, tlast_reg;

    sstq_pkg::slot_t slots [N];
    sstq_pkg::slot_t lefts [N];
    sstq_pkg::slot_t rights [N];
    logic [N:0] dchain, ichain;
    logic drop_en, ins_en;
    logic [CW-1:0] drop_ch;
    sstq_pkg::slot_t ins_slot;

    logic [TW-1:0] arm_exp;
    logic [1:0] cst;
    logic do_arm, do_stop;
    logic [CW-1:0] out_ch;

    logic [N-1:0] due_reg;
    logic [N-1:0] due_now;
    logic [CW-1:0] due_pick;

    logic show;
    logic [TW-1:0] alarm;
    logic [263:0] res_data;

    assign dchain[0] = 1'b0;
    assign ichain[0] = 1'b0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_l
            assign lefts[g] = '0;
        end else begin : g_l
            assign lefts[g] = slots[g-1];
        end
        if (g == N-1) begin : g_r
            assign rights[g] = '0;
        end else begin : g_r
            assign rights[g] = slots[g+1];
        end
        sstq_cell u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .drop_en(drop_en), .drop_ch(drop_ch), .drop_prev(dchain[g]),
            .drop_out(dchain[g+1]),
            .ins_en(ins_en), .ins_slot(ins_slot), .ins_prev(ichain[g]),
            .ins_out(ichain[g+1]),
            .left_slot(lefts[g]), .right_slot(rights[g]), .slot(slots[g])
        );
    end

    assign out_ch = fired_reg ? fch_reg : idx_reg;
    assign arm_exp = sstq_pkg::sat_add(now_reg, dur_reg);

    always_comb begin
        cst = sstq_pkg::ST_OK;
        do_arm = 1'b0;
        do_stop = 1'b0;
        case (cmd_reg)
            sstq_pkg::CMD_ONCE: begin
                if (armed_reg[idx_reg]) cst = sstq_pkg::ST_INVALID_STATE;
                else do_arm = 1'b1;
            end
            sstq_pkg::CMD_PERIODIC: begin
                if (dur_reg == '0) cst = sstq_pkg::ST_INVALID_ARG;
                else if (armed_reg[idx_reg]) cst = sstq_pkg::ST_INVALID_STATE;
                else do_arm = 1'b1;
            end
            sstq_pkg::CMD_RESTART: begin
                if (!armed_reg[idx_reg]) cst = sstq_pkg::ST_INVALID_STATE;
                else do_arm = 1'b1;
            end
            sstq_pkg::CMD_STOP: do_stop = armed_reg[idx_reg];
            sstq_pkg::CMD_QUERY: begin
                if (period_reg[idx_reg] != '0) cst = sstq_pkg::ST_NOT_SUPPORTED;
            end
            default: cst = sstq_pkg::ST_NOT_SUPPORTED;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        drop_en = 1'b0;
        ins_en = 1'b0;
        drop_ch = idx_reg;
        ins_slot.valid = 1'b1;
        ins_slot.ch = idx_reg;
        ins_slot.expiry = expiry_reg[idx_reg];
        s_tready = 1'b0;
        unique case (state_reg)
            sstq_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = (s_tdata[2:0] == sstq_pkg::CMD_TICK) ? sstq_pkg::S_SCAN
                                                                      : sstq_pkg::S_DROP;
                end
            end
            sstq_pkg::S_DROP: begin
                drop_en = ((do_arm && armed_reg[idx_reg]) || do_stop) && !fired_reg;
                drop_ch = fired_reg ? fch_reg : idx_reg;
                if (fired_reg) drop_en = 1'b1;
                state_next = sstq_pkg::S_INSERT;
            end
            sstq_pkg::S_INSERT: begin
                if (fired_reg) begin
                    ins_slot.ch = fch_reg;
                    ins_slot.expiry = expiry_reg[fch_reg];
                    ins_en = armed_reg[fch_reg];
                end else begin
                    ins_en = arm_reg;
                end
                state_next = sstq_pkg::S_OUT;
            end
            sstq_pkg::S_SCAN: state_next = sstq_pkg::S_OUT;
            sstq_pkg::S_FIRE: state_next = sstq_pkg::S_DROP;
            sstq_pkg::S_OUT: begin
                if (!m_tvalid) begin
                    state_next = (cmd_reg == sstq_pkg::CMD_TICK && due_reg != '0)
                                 ? sstq_pkg::S_FIRE : sstq_pkg::S_IDLE;
                end
            end
            default: state_next = sstq_pkg::S_IDLE;
        endcase
    end

    // The due set is captured as a mask at scan time so each channel fires at most once.
    always_comb begin
        due_now = '0;
        for (int i = 0; i < N; i++) begin
            if (slots[i].valid && slots[i].expiry <= now_reg) due_now[slots[i].ch] = 1'b1;
        end
    end
    always_comb begin
        due_pick = '0;
        if (slots[0].valid && due_reg[slots[0].ch]) begin
            due_pick = slots[0].ch;
        end
    end

    assign show = !(cmd_reg == sstq_pkg::CMD_TICK && !fired_reg);
    assign alarm = slots[0].valid ? slots[0].expiry : sstq_pkg::TIME_MAX;

    assign res_data[2:0] = out_ch;
    assign res_data[4:3] = st_reg;
    assign res_data[5] = show ? armed_reg[out_ch] : 1'b0;
    assign res_data[68:6] = show ? period_reg[out_ch] : '0;
    assign res_data[131:69] = show ? expiry_reg[out_ch] : '0;
    assign res_data[194:132] = alarm;
    assign res_data[257:195] = now_reg;
    assign res_data[263:258] = '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sstq_pkg::S_IDLE;
            now_reg <= '0;
            armed_reg <= '0;
            m_tvalid <= 1'b0;
            fired_reg <= 1'b0;
            due_reg <= '0;
            for (int i = 0; i < N; i++) begin
                period_reg[i] <= '0;
                expiry_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            unique case (state_reg)
                sstq_pkg::S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        cmd_reg <= s_tdata[2:0];
                        idx_reg <= s_tdata[5:3];
                        dur_reg <= s_tdata[68:6];
                        fired_reg <= 1'b0;
                        if (s_tdata[2:0] == sstq_pkg::CMD_TICK) begin
                            now_reg <= sstq_pkg::sat_add(now_reg, {{(TW-1){1'b0}}, 1'b1});
                        end
                    end
                end
                sstq_pkg::S_DROP: begin
                    st_reg <= fired_reg ? sstq_pkg::ST_OK : cst;
                    if (!fired_reg) begin
                        arm_reg <= do_arm;
                        if (do_arm) begin
                            armed_reg[idx_reg] <= 1'b1;
                            expiry_reg[idx_reg] <= arm_exp;
                            if (cmd_reg == sstq_pkg::CMD_ONCE) period_reg[idx_reg] <= '0;
                            if (cmd_reg == sstq_pkg::CMD_PERIODIC) period_reg[idx_reg] <= dur_reg;
                        end
                        if (do_stop) armed_reg[idx_reg] <= 1'b0;
                    end else begin
                        if (period_reg[fch_reg] != '0) begin
                            expiry_reg[fch_reg] <= sstq_pkg::sat_add(now_reg, period_reg[fch_reg]);
                        end else begin
                            armed_reg[fch_reg] <= 1'b0;
                        end
                    end
                end
                sstq_pkg::S_INSERT: begin
                    kind_reg <= fired_reg;
                end
                sstq_pkg::S_SCAN: begin
                    due_reg <= due_now;
                    kind_reg <= 1'b0;
                    st_reg <= sstq_pkg::ST_OK;
                    idx_reg <= '0;
                end
                sstq_pkg::S_FIRE: begin
                    fch_reg <= due_pick;
                    due_reg[due_pick] <= 1'b0;
                end
                sstq_pkg::S_OUT: begin
                    if (!m_tvalid) begin
                        if (cmd_reg == sstq_pkg::CMD_TICK && !fired_reg && due_reg != '0) begin
                            fired_reg <= 1'b1;
                        end else begin
                            m_tvalid <= 1'b1;
                            tdata_reg <= res_data;
                            tuser_reg <= kind_reg;
                            tlast_reg <= !fired_reg || (due_reg == '0);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tuser = tuser_reg;
    assign m_tlast = tlast_reg;
    assign m_tdata = tdata_reg;

    `ASSERT_IMPL(a_ready_idle, aclk, aresetn, s_tready, state_reg == sstq_pkg::S_IDLE)
    `ASSERT_IMPL(a_head_sorted, aclk, aresetn, slots[1].valid,
        slots[0].valid && slots[0].expiry <= slots[1].expiry)
    `ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the sorted timer queue: drives requests, predicts results, checks them.
`timescale 1ns / 100ps
module tb_top;
    localparam int TW = sstq_pkg::TIME_W;
    localparam int CW = sstq_pkg::CH_W;
    localparam int NCH = sstq_pkg::NUM_CHANNELS;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [2:0] CMD_BAD6 = 3'd6;
    localparam logic [2:0] CMD_BAD7 = 3'd7;

    typedef struct {
        logic          kind;
        logic [CW-1:0] chan;
        logic [1:0]    status;
        logic          active;
        logic [TW-1:0] period;
        logic [TW-1:0] expiry;
        logic [TW-1:0] next_alarm;
        logic [TW-1:0] now;
        logic          last;
    } timer_result_t;

    class timer_scoreboard;
        timer_result_t pending[$];
        int mismatches;

        function void note(timer_result_t r);
            pending.push_back(r);
        endfunction

        function void check(timer_result_t a);
            timer_result_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: kind %0d chan %0d status %0d", a.kind,
                             a.chan, a.status);
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind || a.chan !== e.chan || a.status !== e.status ||
                a.active !== e.active || a.period !== e.period || a.expiry !== e.expiry ||
                a.next_alarm !== e.next_alarm || a.now !== e.now || a.last !== e.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch expected: k%0d c%0d s%0d a%0d p%0h x%0h n%0h t%0h l%0d",
                             e.kind, e.chan, e.status, e.active, e.period, e.expiry,
                             e.next_alarm, e.now, e.last);
                    $display("         actual:   k%0d c%0d s%0d a%0d p%0h x%0h n%0h t%0h l%0d",
                             a.kind, a.chan, a.status, a.active, a.period, a.expiry,
                             a.next_alarm, a.now, a.last);
                end
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [263:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    sorted_software_timer_queue_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    timer_scoreboard sb = new();

    logic [TW-1:0] now_t;
    logic          armed [NCH];
    logic [TW-1:0] per [NCH];
    logic [TW-1:0] exp_at [NCH];
    int            order [NCH];
    int            olen;
    int unsigned   cycles = 0;
    int            stall_mode = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [TW-1:0] time_add(logic [TW-1:0] a, logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? sstq_pkg::TIME_MAX : s[TW-1:0];
    endfunction

    function automatic void order_remove(int ch);
        for (int i = 0; i < olen; i++) begin
            if (order[i] == ch) begin
                for (int j = i; j + 1 < olen; j++) order[j] = order[j + 1];
                olen--;
                return;
            end
        end
    endfunction

    function automatic void order_insert(int ch);
        int pos;
        pos = 0;
        while (pos < olen && exp_at[order[pos]] <= exp_at[ch]) pos++;
        for (int j = olen; j > pos; j--) order[j] = order[j - 1];
        order[pos] = ch;
        olen++;
    endfunction

    function automatic void arm(int ch, logic [TW-1:0] timeout, logic [TW-1:0] p);
        if (armed[ch]) order_remove(ch);
        per[ch] = p;
        exp_at[ch] = time_add(now_t, timeout);
        armed[ch] = 1'b1;
        order_insert(ch);
    endfunction

    function automatic timer_result_t make_result(logic kind, int ch, logic [1:0] st,
                                                  logic show, logic last);
        timer_result_t r;
        r.kind = kind;
        r.chan = ch[CW-1:0];
        r.status = st;
        r.active = show ? armed[ch] : 1'b0;
        r.period = show ? per[ch] : '0;
        r.expiry = show ? exp_at[ch] : '0;
        r.next_alarm = (olen == 0) ? sstq_pkg::TIME_MAX : exp_at[order[0]];
        r.now = now_t;
        r.last = last;
        return r;
    endfunction

    function automatic void predict_request(logic [2:0] cmd, int idx, logic [TW-1:0] dur);
        int due [NCH];
        int ndue;
        logic [1:0] st;
        ndue = 0;
        st = sstq_pkg::ST_OK;
        if (cmd == sstq_pkg::CMD_TICK) begin
            now_t = time_add(now_t, TW'(1));
            while (ndue < olen && exp_at[order[ndue]] <= now_t) begin
                due[ndue] = order[ndue];
                ndue++;
            end
            if (ndue == 0) begin
                sb.note(make_result(1'b0, 0, sstq_pkg::ST_OK, 1'b0, 1'b1));
                return;
            end
            for (int k = 0; k < ndue; k++) begin
                order_remove(due[k]);
                if (per[due[k]] != '0) begin
                    exp_at[due[k]] = time_add(now_t, per[due[k]]);
                    order_insert(due[k]);
                end else begin
                    armed[due[k]] = 1'b0;
                end
                sb.note(make_result(1'b1, due[k], sstq_pkg::ST_OK, 1'b1, k + 1 == ndue));
            end
            return;
        end
        case (cmd)
            sstq_pkg::CMD_ONCE: begin
                if (armed[idx]) st = sstq_pkg::ST_INVALID_STATE;
                else arm(idx, dur, '0);
            end
            sstq_pkg::CMD_PERIODIC: begin
                if (dur == '0) st = sstq_pkg::ST_INVALID_ARG;
                else if (armed[idx]) st = sstq_pkg::ST_INVALID_STATE;
                else arm(idx, dur, dur);
            end
            sstq_pkg::CMD_RESTART: begin
                if (!armed[idx]) st = sstq_pkg::ST_INVALID_STATE;
                else arm(idx, dur, per[idx]);
            end
            sstq_pkg::CMD_STOP: begin
                if (armed[idx]) begin
                    order_remove(idx);
                    armed[idx] = 1'b0;
                end
            end
            sstq_pkg::CMD_QUERY: begin
                st = (per[idx] != '0) ? sstq_pkg::ST_NOT_SUPPORTED : sstq_pkg::ST_OK;
            end
            default: st = sstq_pkg::ST_NOT_SUPPORTED;
        endcase
        sb.note(make_result(1'b0, idx, st, 1'b1, 1'b1));
    endfunction

    task automatic send_request(logic [2:0] cmd, int idx, logic [TW-1:0] dur, int gap);
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, dur, idx[2:0], cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(cmd, idx, dur);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [TW-1:0] random_duration();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return TW'({$urandom, $urandom});
        if (pick == 1) return sstq_pkg::TIME_MAX - TW'($urandom_range(0, 3));
        if (pick == 2) return '0;
        return TW'($urandom_range(1, 12));
    endfunction

    always @(posedge aclk) begin
        timer_result_t a;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                a.chan = m_tdata[2:0];
                a.status = m_tdata[4:3];
                a.active = m_tdata[5];
                a.period = m_tdata[68:6];
                a.expiry = m_tdata[131:69];
                a.next_alarm = m_tdata[194:132];
                a.now = m_tdata[257:195];
                a.kind = m_tuser;
                a.last = m_tlast;
                sb.check(a);
            end
            if (cycles % 512 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= (cycles % 7 < 3);
                default: m_tready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int burst;
        int gap;
        logic [2:0] cmd;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        now_t = '0;
        olen = 0;
        for (int i = 0; i < NCH; i++) begin
            armed[i] = 1'b0;
            per[i] = '0;
            exp_at[i] = '0;
            order[i] = 0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(sstq_pkg::CMD_TICK, 0, '0, 0);
        send_request(sstq_pkg::CMD_ONCE, 0, '0, 1);
        send_request(sstq_pkg::CMD_ONCE, 0, 63'd5, 0);
        send_request(sstq_pkg::CMD_PERIODIC, 1, '0, 0);
        send_request(sstq_pkg::CMD_PERIODIC, 1, 63'd1, 2);
        send_request(sstq_pkg::CMD_PERIODIC, 1, 63'd3, 0);
        send_request(sstq_pkg::CMD_ONCE, 2, 63'd1, 0);
        send_request(sstq_pkg::CMD_ONCE, 3, 63'd1, 0);
        send_request(sstq_pkg::CMD_QUERY, 1, '0, 0);
        send_request(sstq_pkg::CMD_QUERY, 2, '0, 0);
        send_request(sstq_pkg::CMD_TICK, 5, sstq_pkg::TIME_MAX, 0);
        send_request(sstq_pkg::CMD_RESTART, 4, 63'd2, 0);
        send_request(sstq_pkg::CMD_RESTART, 1, 63'd4, 0);
        send_request(sstq_pkg::CMD_STOP, 1, '0, 0);
        send_request(sstq_pkg::CMD_STOP, 1, '0, 0);
        send_request(sstq_pkg::CMD_ONCE, 5, sstq_pkg::TIME_MAX, 0);
        send_request(sstq_pkg::CMD_PERIODIC, 6, sstq_pkg::TIME_MAX, 0);
        send_request(sstq_pkg::CMD_PERIODIC, 7, 63'd2, 0);
        send_request(CMD_BAD6, 7, 63'h2AAA_AAAA_AAAA_AAAA, 0);
        send_request(CMD_BAD7, 6, 63'h5555_5555_5555_5555, 3);
        send_request(sstq_pkg::CMD_TICK, 0, '0, 0);
        send_request(sstq_pkg::CMD_TICK, 0, '0, 0);
        send_request(sstq_pkg::CMD_TICK, 0, '0, 0);

        burst = 0;
        for (int n = 0; n < 300; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 16);
                gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
            end
            burst--;
            cmd = ($urandom_range(0, 9) < 4) ? sstq_pkg::CMD_TICK : 3'($urandom_range(1, 7));
            if (cmd > sstq_pkg::CMD_QUERY && $urandom_range(0, 2) != 0) cmd = sstq_pkg::CMD_ONCE;
            send_request(cmd, $urandom_range(0, NCH - 1), random_duration(),
                         burst == 0 ? gap : 0);
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
